[rtl/positional_pid_controller_assert.svh]
// assertion helpers for the pid controller, clocked on clk_i, off during reset
`ifndef POSITIONAL_PID_CONTROLLER_ASSERT_SVH
`define POSITIONAL_PID_CONTROLLER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PPID_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppid: same-cycle property violated");

// consequent checked in the cycle after the antecedent
`define PPID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppid: next-cycle property violated");

`endif

[rtl/ppid_pkg.sv]
`default_nettype none

package ppid_pkg;

  localparam int GAIN_W     = 32;
  localparam int LIMIT_W    = 16;
  localparam int DRIVE_W    = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [GAIN_W-1:0]  PROP_GAIN_RST   = 32'sd1310720;
  localparam logic signed [GAIN_W-1:0]  INTEG_GAIN_RST  = 32'sd0;
  localparam logic signed [GAIN_W-1:0]  DERIV_GAIN_RST  = 32'sd262144;
  localparam logic        [LIMIT_W-1:0] INTEG_LIMIT_RST = 16'd1000;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

  typedef enum logic {
    CMD_RUN   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = CFG_IDX_W'(0),
    CFG_INTEG_GAIN  = CFG_IDX_W'(1),
    CFG_DERIV_GAIN  = CFG_IDX_W'(2),
    CFG_INTEG_LIMIT = CFG_IDX_W'(3)
  } cfg_reg_e;

  // status carried from the integrator stage to the output stage
  typedef struct packed {
    logic clear;
    logic integ_clamped;
  } stage_flags_t;

  function automatic int max_w(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

[rtl/ppid_if.sv]
`default_nettype none

interface ppid_step_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [DATA_WIDTH-1:0] measured;
  logic signed [DATA_WIDTH-1:0] setpoint;

  modport source (output valid, output command, output measured, output setpoint,
                  input ready);
  modport sink   (input valid, input command, input measured, input setpoint,
                  output ready);
endinterface

interface ppid_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ppid_pkg::DRIVE_W-1:0]  drive;
  logic                                 integ_clamped;
  logic                                 drive_saturated;

  modport source (output valid, output drive, output integ_clamped,
                  output drive_saturated, input ready);
  modport sink   (input valid, input drive, input integ_clamped,
                  input drive_saturated, output ready);
endinterface

interface ppid_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ppid_pkg::CFG_IDX_W-1:0]    index;
  logic [ppid_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/ppid_front.sv]
`default_nettype none

module ppid_front #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic                           command_i,
  input  wire logic signed [DATA_WIDTH-1:0]   measured_i,
  input  wire logic signed [DATA_WIDTH-1:0]   setpoint_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic                           clear_o,
  output      logic signed [DATA_WIDTH:0]     err_o,
  output      logic signed [DATA_WIDTH+1:0]   diff_o
);

  localparam int ERR_W  = DATA_WIDTH + 1;
  localparam int DIFF_W = DATA_WIDTH + 2;

  logic                     valid_q;
  logic                     accept;
  logic                     clear_d;
  logic signed [ERR_W-1:0]  err_d;
  logic signed [DIFF_W-1:0] diff_d;
  logic signed [ERR_W-1:0]  prev_err_q;
  logic                     clear_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [DIFF_W-1:0] diff_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign clear_d = (command_i == ppid_pkg::CMD_CLEAR);
  assign err_d   = ERR_W'(setpoint_i) - ERR_W'(measured_i);
  assign diff_d  = DIFF_W'(err_d) - DIFF_W'(prev_err_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      prev_err_q <= '0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (accept) begin
        prev_err_q <= clear_d ? '0 : err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      clear_q <= clear_d;
      err_q   <= err_d;
      diff_q  <= diff_d;
    end
  end

  assign out_valid_o = valid_q;
  assign clear_o     = clear_q;
  assign err_o       = err_q;
  assign diff_o      = diff_q;

endmodule

`default_nettype wire

[rtl/ppid_mult.sv]
`default_nettype none

module ppid_mult #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      in_valid_i,
  output      logic                                      in_ready_o,
  input  wire logic                                      clear_i,
  input  wire logic signed [DATA_WIDTH:0]                err_i,
  input  wire logic signed [DATA_WIDTH+1:0]              diff_i,
  input  wire logic signed [ppid_pkg::GAIN_W-1:0]        prop_gain_i,
  input  wire logic signed [ppid_pkg::GAIN_W-1:0]        integ_gain_i,
  input  wire logic signed [ppid_pkg::GAIN_W-1:0]        deriv_gain_i,
  output      logic                                      out_valid_o,
  input  wire logic                                      out_ready_i,
  output      logic                                      clear_o,
  output      logic signed [ppid_pkg::GAIN_W+DATA_WIDTH:0]   prod_p_o,
  output      logic signed [ppid_pkg::GAIN_W+DATA_WIDTH:0]   prod_i_o,
  output      logic signed [ppid_pkg::GAIN_W+DATA_WIDTH+1:0] prod_d_o
);

  localparam int PROD_W   = ppid_pkg::GAIN_W + DATA_WIDTH + 1;
  localparam int PROD_D_W = ppid_pkg::GAIN_W + DATA_WIDTH + 2;

  logic                       valid_q;
  logic                       accept;
  logic signed [PROD_W-1:0]   prod_p_d;
  logic signed [PROD_W-1:0]   prod_i_d;
  logic signed [PROD_D_W-1:0] prod_d_d;
  logic                       clear_q;
  logic signed [PROD_W-1:0]   prod_p_q;
  logic signed [PROD_W-1:0]   prod_i_q;
  logic signed [PROD_D_W-1:0] prod_d_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // three independent multipliers, each at most 32 x 18
  assign prod_p_d = PROD_W'(err_i) * PROD_W'(prop_gain_i);
  assign prod_i_d = PROD_W'(err_i) * PROD_W'(integ_gain_i);
  assign prod_d_d = PROD_D_W'(diff_i) * PROD_D_W'(deriv_gain_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      clear_q  <= clear_i;
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
    end
  end

  assign out_valid_o = valid_q;
  assign clear_o     = clear_q;
  assign prod_p_o    = prod_p_q;
  assign prod_i_o    = prod_i_q;
  assign prod_d_o    = prod_d_q;

endmodule

`default_nettype wire

[rtl/ppid_integ.sv]
`default_nettype none

module ppid_integ #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          in_valid_i,
  output      logic                                          in_ready_o,
  input  wire logic                                          clear_i,
  input  wire logic signed [ppid_pkg::GAIN_W+DATA_WIDTH:0]   prod_p_i,
  input  wire logic signed [ppid_pkg::GAIN_W+DATA_WIDTH:0]   prod_i_i,
  input  wire logic signed [ppid_pkg::GAIN_W+DATA_WIDTH+1:0] prod_d_i,
  input  wire logic        [ppid_pkg::LIMIT_W-1:0]           integ_limit_i,
  output      logic                                          out_valid_o,
  input  wire logic                                          out_ready_i,
  output      ppid_pkg::stage_flags_t                        flags_o,
  output      logic signed [ppid_pkg::GAIN_W+DATA_WIDTH+2:0] pd_sum_o,
  output      logic signed [ppid_pkg::LIMIT_W+GAIN_FRAC_BITS:0] integ_o
);

  localparam int PROD_W   = ppid_pkg::GAIN_W + DATA_WIDTH + 1;
  localparam int PROD_D_W = ppid_pkg::GAIN_W + DATA_WIDTH + 2;
  localparam int PD_W     = PROD_D_W + 1;
  localparam int INTEG_W  = ppid_pkg::LIMIT_W + GAIN_FRAC_BITS + 1;
  localparam int SUMI_W   = ppid_pkg::max_w(PROD_W, INTEG_W) + 1;

  logic                        valid_q;
  logic                        accept;
  logic        [SUMI_W-1:0]    lim_u;
  logic signed [SUMI_W-1:0]    lim_pos;
  logic signed [SUMI_W-1:0]    lim_neg;
  logic signed [SUMI_W-1:0]    sum;
  logic signed [SUMI_W-1:0]    sum_clamped;
  logic                        clamp_d;
  logic signed [INTEG_W-1:0]   integ_d;
  logic signed [PD_W-1:0]      pd_sum_d;
  logic signed [INTEG_W-1:0]   integ_q;
  ppid_pkg::stage_flags_t      flags_q;
  logic signed [PD_W-1:0]      pd_sum_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // limit is an integer, the accumulator carries the gain fraction
  assign lim_u   = SUMI_W'(integ_limit_i) << GAIN_FRAC_BITS;
  assign lim_pos = $signed(lim_u);
  assign lim_neg = -lim_pos;
  assign sum     = SUMI_W'(integ_q) + SUMI_W'(prod_i_i);

  // reaching a bound counts as clamped, so a zero limit always clamps
  always_comb begin
    clamp_d     = 1'b1;
    sum_clamped = sum;
    priority if (sum >= lim_pos) begin
      sum_clamped = lim_pos;
    end else if (sum <= lim_neg) begin
      sum_clamped = lim_neg;
    end else begin
      clamp_d = 1'b0;
    end
  end

  assign integ_d  = clear_i ? '0 : INTEG_W'(sum_clamped);
  assign pd_sum_d = PD_W'(prod_p_i) + PD_W'(prod_d_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      integ_q <= '0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (accept) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flags_q.clear         <= clear_i;
      flags_q.integ_clamped <= clamp_d && !clear_i;
      pd_sum_q              <= pd_sum_d;
    end
  end

  assign out_valid_o = valid_q;
  assign flags_o     = flags_q;
  assign pd_sum_o    = pd_sum_q;
  assign integ_o     = integ_q;

endmodule

`default_nettype wire

[rtl/ppid_out.sv]
`default_nettype none

module ppid_out #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                                             clk_i,
  input  wire logic                                             rst_ni,
  input  wire logic                                             in_valid_i,
  output      logic                                             in_ready_o,
  input  wire ppid_pkg::stage_flags_t                           flags_i,
  input  wire logic signed [ppid_pkg::GAIN_W+DATA_WIDTH+2:0]    pd_sum_i,
  input  wire logic signed [ppid_pkg::LIMIT_W+GAIN_FRAC_BITS:0] integ_i,
  output      logic                                             res_valid_o,
  input  wire logic                                             res_ready_i,
  output      logic signed [ppid_pkg::DRIVE_W-1:0]              drive_o,
  output      logic                                             integ_clamped_o,
  output      logic                                             drive_saturated_o
);

  localparam int PD_W    = ppid_pkg::GAIN_W + DATA_WIDTH + 3;
  localparam int INTEG_W = ppid_pkg::LIMIT_W + GAIN_FRAC_BITS + 1;
  localparam int TOT_W   = ppid_pkg::max_w(PD_W, INTEG_W) + 1;
  localparam int EXT_W   = ppid_pkg::max_w(TOT_W, ppid_pkg::DRIVE_W + 1);

  logic                                valid_q;
  logic                                accept;
  logic signed [EXT_W-1:0]             total;
  logic signed [EXT_W-1:0]             bias;
  logic signed [EXT_W-1:0]             quot;
  logic signed [ppid_pkg::DRIVE_W-1:0] drive_d;
  logic                                sat_d;
  logic signed [ppid_pkg::DRIVE_W-1:0] drive_q;
  logic                                clamped_q;
  logic                                sat_q;

  assign in_ready_o = !valid_q || res_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign total = EXT_W'(pd_sum_i) + EXT_W'(integ_i);
  // truncation toward zero: negative sums get the fraction mask added first
  assign bias  = total[EXT_W-1] ? EXT_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1) : '0;
  assign quot  = (total + bias) >>> GAIN_FRAC_BITS;

  always_comb begin
    sat_d   = 1'b1;
    drive_d = ppid_pkg::DRIVE_MAX;
    priority if (flags_i.clear) begin
      sat_d   = 1'b0;
      drive_d = '0;
    end else if (quot > EXT_W'(ppid_pkg::DRIVE_MAX)) begin
      drive_d = ppid_pkg::DRIVE_MAX;
    end else if (quot < EXT_W'(ppid_pkg::DRIVE_MIN)) begin
      drive_d = ppid_pkg::DRIVE_MIN;
    end else begin
      sat_d   = 1'b0;
      drive_d = ppid_pkg::DRIVE_W'(quot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drive_q   <= drive_d;
      clamped_q <= flags_i.integ_clamped;
      sat_q     <= sat_d;
    end
  end

  assign res_valid_o       = valid_q;
  assign drive_o           = drive_q;
  assign integ_clamped_o   = clamped_q;
  assign drive_saturated_o = sat_q;

endmodule

`default_nettype wire

[rtl/positional_pid_controller.sv]
// channel   dir  modport  payload
// step_i    in   sink     command, measured, setpoint
// result_o  out  source   drive, integ_clamped, drive_saturated
// cfg_i     in   sink     index, data (always ready)
//
// one beat accepted per cycle unless a stalled output has filled the stages, one result beat per step beat,
// four register stages (error, multiply, integrate, output)
// the integral feedback closes in the integrator stage, one add and clamp a cycle while that stage accepts
// each stage holds its own valid, so beats keep entering while a result waits
// and a stalled output fills the four stages before step_i.ready drops
// asynchronous reset clears stage valids, integral and last error, reloads the gains and limit
`default_nettype none

module positional_pid_controller #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ppid_step_if.sink      step_i,
  ppid_result_if.source  result_o,
  ppid_cfg_if.sink       cfg_i
);

  localparam int ERR_W    = DATA_WIDTH + 1;
  localparam int DIFF_W   = DATA_WIDTH + 2;
  localparam int PROD_W   = ppid_pkg::GAIN_W + DATA_WIDTH + 1;
  localparam int PROD_D_W = ppid_pkg::GAIN_W + DATA_WIDTH + 2;
  localparam int PD_W     = PROD_D_W + 1;
  localparam int INTEG_W  = ppid_pkg::LIMIT_W + GAIN_FRAC_BITS + 1;

  // gain and limit registers; the user writes them only while the pipeline is empty, the block does not enforce it
  logic signed [ppid_pkg::GAIN_W-1:0] prop_gain_q;
  logic signed [ppid_pkg::GAIN_W-1:0] integ_gain_q;
  logic signed [ppid_pkg::GAIN_W-1:0] deriv_gain_q;
  logic        [ppid_pkg::LIMIT_W-1:0] integ_limit_q;
  logic                                cfg_write;

  // error stage to multiply stage
  logic                     s1_valid;
  logic                     s1_ready;
  logic                     s1_clear;
  logic signed [ERR_W-1:0]  s1_err;
  logic signed [DIFF_W-1:0] s1_diff;

  // multiply stage to integrator stage
  logic                       s2_valid;
  logic                       s2_ready;
  logic                       s2_clear;
  logic signed [PROD_W-1:0]   s2_prod_p;
  logic signed [PROD_W-1:0]   s2_prod_i;
  logic signed [PROD_D_W-1:0] s2_prod_d;

  // integrator stage to output stage
  logic                      s3_valid;
  logic                      s3_ready;
  ppid_pkg::stage_flags_t    s3_flags;
  logic signed [PD_W-1:0]    s3_pd_sum;
  logic signed [INTEG_W-1:0] s3_integ;

  logic                      step_beat;
  logic signed [INTEG_W-1:0] integ_lim;

  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= ppid_pkg::PROP_GAIN_RST;
      integ_gain_q  <= ppid_pkg::INTEG_GAIN_RST;
      deriv_gain_q  <= ppid_pkg::DERIV_GAIN_RST;
      integ_limit_q <= ppid_pkg::INTEG_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_i.index)
        ppid_pkg::CFG_PROP_GAIN: begin
          prop_gain_q <= $signed(cfg_i.data[ppid_pkg::GAIN_W-1:0]);
        end
        ppid_pkg::CFG_INTEG_GAIN: begin
          integ_gain_q <= $signed(cfg_i.data[ppid_pkg::GAIN_W-1:0]);
        end
        ppid_pkg::CFG_DERIV_GAIN: begin
          deriv_gain_q <= $signed(cfg_i.data[ppid_pkg::GAIN_W-1:0]);
        end
        ppid_pkg::CFG_INTEG_LIMIT: begin
          integ_limit_q <= cfg_i.data[ppid_pkg::LIMIT_W-1:0];
        end
        default: begin
          // unmapped index, write ignored
        end
      endcase
    end
  end

  // error and error difference, last error kept here
  ppid_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (step_i.valid),
    .in_ready_o  (step_i.ready),
    .command_i   (step_i.command),
    .measured_i  (step_i.measured),
    .setpoint_i  (step_i.setpoint),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .clear_o     (s1_clear),
    .err_o       (s1_err),
    .diff_o      (s1_diff)
  );

  // the three gain products, registered
  ppid_mult #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mult (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s1_valid),
    .in_ready_o   (s1_ready),
    .clear_i      (s1_clear),
    .err_i        (s1_err),
    .diff_i       (s1_diff),
    .prop_gain_i  (prop_gain_q),
    .integ_gain_i (integ_gain_q),
    .deriv_gain_i (deriv_gain_q),
    .out_valid_o  (s2_valid),
    .out_ready_i  (s2_ready),
    .clear_o      (s2_clear),
    .prod_p_o     (s2_prod_p),
    .prod_i_o     (s2_prod_i),
    .prod_d_o     (s2_prod_d)
  );

  // clamped integral accumulator, plus proportional and derivative sum
  ppid_integ #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_integ (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s2_valid),
    .in_ready_o    (s2_ready),
    .clear_i       (s2_clear),
    .prod_p_i      (s2_prod_p),
    .prod_i_i      (s2_prod_i),
    .prod_d_i      (s2_prod_d),
    .integ_limit_i (integ_limit_q),
    .out_valid_o   (s3_valid),
    .out_ready_i   (s3_ready),
    .flags_o       (s3_flags),
    .pd_sum_o      (s3_pd_sum),
    .integ_o       (s3_integ)
  );

  // final sum, scale down toward zero, saturate, result register
  ppid_out #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s3_valid),
    .in_ready_o        (s3_ready),
    .flags_i           (s3_flags),
    .pd_sum_i          (s3_pd_sum),
    .integ_i           (s3_integ),
    .res_valid_o       (result_o.valid),
    .res_ready_i       (result_o.ready),
    .drive_o           (result_o.drive),
    .integ_clamped_o   (result_o.integ_clamped),
    .drive_saturated_o (result_o.drive_saturated)
  );

  // checks
  assign step_beat = step_i.valid && step_i.ready;
  assign integ_lim = $signed(INTEG_W'(integ_limit_q) << GAIN_FRAC_BITS);

`include "positional_pid_controller_assert.svh"

  // a clear wipes the last error, so the next step's difference is its error
  `PPID_ASSERT_NEXT(a_clear_zeroes_last_err, step_beat && step_i.command == ppid_pkg::CMD_CLEAR ##1 step_beat, s1_diff == DIFF_W'(s1_err))

  // a clamped step leaves the integral sitting on one of the bounds
  `PPID_ASSERT_SAME(a_clamp_on_bound, s3_valid && s3_flags.integ_clamped, s3_integ == integ_lim || s3_integ == -integ_lim)

  // a clear step leaves the integral at zero
  `PPID_ASSERT_SAME(a_clear_zeroes_integ, s3_valid && s3_flags.clear, s3_integ == '0)

  // a saturated result sits on one of the 32-bit limits
  `PPID_ASSERT_SAME(a_sat_on_limit, result_o.valid && result_o.drive_saturated, result_o.drive == ppid_pkg::DRIVE_MAX || result_o.drive == ppid_pkg::DRIVE_MIN)

endmodule

`default_nettype wire

[verif/tb_positional_pid_controller.sv]
`default_nettype none

module tb_positional_pid_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import ppid_pkg::*;

  localparam int     CLK_PERIOD      = 12;
  localparam int     FRAC            = 16;
  localparam int     SETTLE_CYCLES   = 8;     // pipeline is four stages deep
  localparam int     WATCHDOG_LIMIT  = 2000;
  localparam int     HOLD_CYCLES     = 40;
  localparam int     RAND_PHASES     = 9;
  localparam int     ITEMS_PER_PHASE = 87;
  localparam int     PRESSURE_PHASE  = 7;
  localparam int     REPORT_MAX      = 10;
  localparam longint I64_MAX         = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN         = 64'sh8000_0000_0000_0000;
  localparam longint I32_MAX         = 64'sd2147483647;
  localparam longint I32_MIN         = -64'sd2147483648;

  // index that decodes to no register, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(9);

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic                      integ_clamped;
    logic                      drive_saturated;
  } pid_result_t;

  // mirror of the controller: gains, limit, integral and last error,
  // plus the queue of drives still owed by the block
  class pid_check;
    logic signed [GAIN_W-1:0] kp_q;
    logic signed [GAIN_W-1:0] ki_q;
    logic signed [GAIN_W-1:0] kd_q;
    logic [LIMIT_W-1:0]       lim_q;
    longint                   integ_acc;
    longint                   last_err;
    pid_result_t              drives_due[$];
    int                       faults;

    function new();
      kp_q      = 32'sd1310720;
      ki_q      = 32'sd0;
      kd_q      = 32'sd262144;
      lim_q     = 16'd1000;
      integ_acc = 0;
      last_err  = 0;
      faults    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PROP_GAIN:   kp_q  = val;
        CFG_INTEG_GAIN:  ki_q  = val;
        CFG_DERIV_GAIN:  kd_q  = val;
        CFG_INTEG_LIMIT: lim_q = val[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function longint add_sat(longint a, longint b);
      if (b > 0 && a > I64_MAX - b) return I64_MAX;
      if (b < 0 && a < I64_MIN - b) return I64_MIN;
      return a + b;
    endfunction

    // one control step on an accepted beat
    function void take_step(cmd_e cmd, logic signed [15:0] meas, logic signed [15:0] setp);
      longint      err;
      longint      lim;
      longint      total;
      longint      q;
      pid_result_t r;
      r.drive           = '0;
      r.integ_clamped   = 1'b0;
      r.drive_saturated = 1'b0;
      if (cmd == CMD_CLEAR) begin
        integ_acc = 0;
        last_err  = 0;
        drives_due.push_back(r);
        return;
      end
      err = longint'(setp) - longint'(meas);
      lim = longint'(lim_q) << FRAC;
      integ_acc = add_sat(integ_acc, longint'(ki_q) * err);
      // touching a bound counts as clamped, zero limit clamps every step
      if (integ_acc >= lim) begin
        integ_acc       = lim;
        r.integ_clamped = 1'b1;
      end else if (integ_acc <= -lim) begin
        integ_acc       = -lim;
        r.integ_clamped = 1'b1;
      end
      total = add_sat(longint'(kp_q) * err, integ_acc);
      total = add_sat(total, longint'(kd_q) * (err - last_err));
      q = total / (longint'(1) << FRAC);
      if (q > I32_MAX) begin
        q                 = I32_MAX;
        r.drive_saturated = 1'b1;
      end else if (q < I32_MIN) begin
        q                 = I32_MIN;
        r.drive_saturated = 1'b1;
      end
      r.drive  = q[DRIVE_W-1:0];
      last_err = err;
      drives_due.push_back(r);
    endfunction

    function void check_drive(pid_result_t got);
      pid_result_t want;
      if (drives_due.size() == 0) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("result beat with nothing due: drive %0d clamp %0b sat %0b",
                   got.drive, got.integ_clamped, got.drive_saturated);
        return;
      end
      want = drives_due.pop_front();
      if (got.drive !== want.drive || got.integ_clamped !== want.integ_clamped ||
          got.drive_saturated !== want.drive_saturated) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("mismatch: drive exp %0d got %0d, clamp exp %0b got %0b, sat exp %0b got %0b",
                   want.drive, got.drive, want.integ_clamped, got.integ_clamped,
                   want.drive_saturated, got.drive_saturated);
      end
    endfunction

    function int pending();
      return drives_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ppid_step_if #(.DATA_WIDTH(16)) step_bus ();
  ppid_result_if                  result_bus ();
  ppid_cfg_if                     cfg_bus ();

  positional_pid_controller #(
    .DATA_WIDTH    (16),
    .GAIN_FRAC_BITS(FRAC)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step_bus),
    .result_o(result_bus),
    .cfg_i   (cfg_bus)
  );

  pid_check sb = new();

  // idle percentages, changed by the stimulus between phases
  int send_idle_pct = 8;
  int recv_idle_pct = 73;
  bit hold_off_req  = 1'b0;
  int quiet_cycles  = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // beat monitor and watchdog, all sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready)
        sb.check_drive('{drive: result_bus.drive, integ_clamped: result_bus.integ_clamped,
                         drive_saturated: result_bus.drive_saturated});
      if (step_bus.valid && step_bus.ready)
        sb.take_step(cmd_e'(step_bus.command), step_bus.measured, step_bus.setpoint);
      if (cfg_bus.valid && cfg_bus.ready)
        sb.set_reg(cfg_bus.index, cfg_bus.data);
      if ((result_bus.valid && result_bus.ready) || (step_bus.valid && step_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[positional_pid_controller] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    result_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_bus.ready <= 1'b0;
        // sender keeps offering, so the four stages fill and step ready drops
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid is left high after a beat so back-to-back beats never toggle it
  task automatic offer_step(input cmd_e cmd, input logic signed [15:0] meas,
                            input logic signed [15:0] setp);
    while ($urandom_range(99) < send_idle_pct) begin
      step_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    step_bus.valid    <= 1'b1;
    step_bus.command  <= cmd;
    step_bus.measured <= meas;
    step_bus.setpoint <= setp;
    do @(posedge clk_i); while (!step_bus.ready);
  endtask

  task automatic offer_random_step();
    int                 pick;
    int                 delta;
    logic signed [15:0] setp;
    logic signed [15:0] meas;
    pick = $urandom_range(99);
    setp = 16'($urandom);
    meas = 16'($urandom);
    if (pick < 45) begin
      // small error, lets the integral creep towards its bound
      delta = $urandom_range(600) - 300;
      meas  = 16'(setp + delta);
    end else if (pick < 75) begin
      setp = 16'($urandom_range(4000) - 2000);
      meas = 16'($urandom_range(4000) - 2000);
    end
    offer_step((pick >= 95) ? CMD_CLEAR : CMD_RUN, meas, setp);
  endtask

  // drop valid, wait for every owed drive, then let the pipe empty
  task automatic settle();
    step_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // limit register is 16 bits, upper data bits are junk and must be dropped
  task automatic apply_setting(input logic [31:0] kp, input logic [31:0] ki,
                               input logic [31:0] kd, input logic [15:0] lim);
    write_cfg(CFG_PROP_GAIN, kp);
    write_cfg(CFG_INTEG_GAIN, ki);
    write_cfg(CFG_DERIV_GAIN, kd);
    write_cfg(CFG_INTEG_LIMIT, {16'($urandom), lim});
  endtask

  function automatic logic [31:0] rand_gain();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 32'($urandom_range(64 << FRAC) - (32 << FRAC));
    if (pick < 85) return $urandom;
    case ($urandom_range(2))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [15:0] rand_limit();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return 16'($urandom_range(2000));
    if (pick < 80) return 16'($urandom);
    return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0;
  endfunction

  initial begin
    rst_ni            <= 1'b0;
    step_bus.valid    <= 1'b0;
    step_bus.command  <= CMD_RUN;
    step_bus.measured <= '0;
    step_bus.setpoint <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= CFG_PROP_GAIN;
    cfg_bus.data      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset gains: field extremes, zero error, largest error swings
    offer_step(CMD_RUN, 16'sd0, 16'sd0);
    offer_step(CMD_RUN, -16'sd32768, 16'sd32767);
    offer_step(CMD_RUN, 16'sd32767, -16'sd32768);
    offer_step(CMD_RUN, 16'sd32767, 16'sd32767);
    offer_step(CMD_RUN, -16'sd32768, -16'sd32768);
    offer_step(CMD_CLEAR, 16'sd1234, -16'sd4321);
    offer_step(CMD_RUN, 16'sd100, 16'sd200);
    offer_step(CMD_RUN, 16'sd1, 16'sd0);
    settle();

    // gain 10.0 against limit 30: third step lands exactly on the bound
    apply_setting(32'sd1310720, 32'sd655360, 32'sd262144, 16'd30);
    write_cfg(CFG_SPARE_IDX, 32'hDEAD_BEEF);
    repeat (4) offer_step(CMD_RUN, 16'sd0, 16'sd1);
    repeat (7) offer_step(CMD_RUN, 16'sd1, 16'sd0);
    offer_step(CMD_CLEAR, -16'sd1, 16'sd1);
    settle();

    // zero limit holds the integral at zero and clamps every step
    write_cfg(CFG_INTEG_LIMIT, 32'hFFFF_0000);
    offer_step(CMD_RUN, 16'sd5, -16'sd5);
    offer_step(CMD_RUN, -16'sd300, 16'sd300);
    settle();

    // largest gains: the unscaled sum runs far past the drive range
    apply_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    offer_step(CMD_RUN, -16'sd32768, 16'sd32767);
    offer_step(CMD_RUN, 16'sd32767, -16'sd32768);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      send_idle_pct = (p < 3) ? 8 : (p < 6) ? 73 : 0;
      recv_idle_pct = (p < 3) ? 73 : (p < 6) ? 8 : 0;
      if (p == 0)
        apply_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
      else if (p == 1)
        apply_setting(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0);
      else
        apply_setting(rand_gain(), rand_gain(), rand_gain(), rand_limit());
      if (p == PRESSURE_PHASE) hold_off_req = 1'b1;
      repeat (ITEMS_PER_PHASE) offer_random_step();
      settle();
    end

    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("[positional_pid_controller] OK");
    end else begin
      $display("[positional_pid_controller] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
